[sv/display_key_frame_receiver_top_macros.svh]
// Assertion macros for the display key frame receiver.
// Depends on clk and arst_n being visible where a macro is used.
`ifndef DISPLAY_KEY_FRAME_RECEIVER_TOP_MACROS_SVH
`define DISPLAY_KEY_FRAME_RECEIVER_TOP_MACROS_SVH

// Check a property on every clock edge outside reset.
`define DKF_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define DKF_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[sv/dkf_pkg.sv]
// Types, constants and key lookup for the display key frame receiver.
// No dependencies.
package dkf_pkg;

	localparam int DKF_MAX_PAYLOAD = 6;
	localparam int BYTE_W          = 8;
	localparam int KEY_ID_W        = 3;
	localparam int FRAME_LEN_W     = 3;
	localparam int REPORT_LEN      = 6;
	localparam int KEY_BYTES       = REPORT_LEN - 1;
	localparam int KEY_IDX_W       = $clog2(KEY_BYTES);

	localparam logic [BYTE_W-1:0] HDR_FIRST  = 8'h5A;
	localparam logic [BYTE_W-1:0] HDR_SECOND = 8'hA5;
	localparam logic [BYTE_W-1:0] TOUCH_CMD  = 8'h83;
	localparam logic [BYTE_W-1:0] ADDR_BYTE3 = 8'h01;
	localparam logic [BYTE_W-1:0] ADDR_BYTE4 = 8'h00;
	localparam logic [BYTE_W-1:0] PAGE_A     = 8'h16;
	localparam logic [BYTE_W-1:0] PAGE_B     = 8'h18;
	localparam logic [BYTE_W-1:0] SLOT_0     = 8'h00;
	localparam logic [BYTE_W-1:0] SLOT_1     = 8'h20;
	localparam logic [BYTE_W-1:0] SLOT_2     = 8'h40;
	localparam logic [BYTE_W-1:0] SLOT_3     = 8'h60;

	typedef enum logic [1:0] {
		PH_HUNT,
		PH_HDR2,
		PH_LEN,
		PH_DATA
	} phase_t;

	typedef struct packed {
		logic                hit;
		logic [KEY_ID_W-1:0] id;
	} key_hit_t;

	function automatic key_hit_t dkf_key_lookup(input logic [BYTE_W-1:0] hi,
			input logic [BYTE_W-1:0] lo);
		key_hit_t r;
		r = '0;
		if (hi == PAGE_A) begin
			if (lo == SLOT_0) r = '{1'b1, 3'd0};
			else if (lo == SLOT_1) r = '{1'b1, 3'd1};
			else if (lo == SLOT_2) r = '{1'b1, 3'd2};
			else if (lo == SLOT_3) r = '{1'b1, 3'd3};
		end else if (hi == PAGE_B) begin
			if (lo == SLOT_0) r = '{1'b1, 3'd4};
			else if (lo == SLOT_1) r = '{1'b1, 3'd5};
			else if (lo == SLOT_2) r = '{1'b1, 3'd6};
		end
		return r;
	endfunction

endpackage

[sv/dkf_in_if.sv]
// Input channel: one received serial byte per word.
// Depends on dkf_pkg.
interface dkf_in_if;
	logic                       valid;
	logic                       ready;
	logic [dkf_pkg::BYTE_W-1:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

[sv/dkf_out_if.sv]
// Output channel: one decoded frame result per word.
// Depends on dkf_pkg.
interface dkf_out_if;
	logic                            valid;
	logic                            ready;
	logic                            matched;
	logic [dkf_pkg::KEY_ID_W-1:0]    key_id;
	logic [dkf_pkg::BYTE_W-1:0]      key_value;
	logic [dkf_pkg::FRAME_LEN_W-1:0] frame_length;

	modport source (output valid, output matched, output key_id, output key_value,
		output frame_length, input ready);
	modport sink (input valid, input matched, input key_id, input key_value,
		input frame_length, output ready);
endinterface

[sv/display_key_frame_receiver_top.sv]
// Display key frame receiver: 0x5A 0xA5 header hunt, length deframing, key report decode.
// Timing: a result word is presented once the frame's last byte has passed the input register
// and then the result register. Throughput: one byte per cycle while no stall holds (below).
// The input register stalls only while a finished result waits in a full result register.
// Reset: asynchronous, active low; clears sync phase, count, length and valids.
// Depends on dkf_pkg, dkf_in_if, dkf_out_if and display_key_frame_receiver_top_macros.svh.
`include "display_key_frame_receiver_top_macros.svh"

module display_key_frame_receiver_top #(
	parameter int MAX_PAYLOAD = dkf_pkg::DKF_MAX_PAYLOAD
) (
	input logic clk,
	input logic arst_n,
	dkf_in_if.sink    din,
	dkf_out_if.source dout
);
	import dkf_pkg::*;

	localparam int LEN_W = $clog2(MAX_PAYLOAD + 1);

	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;

	phase_t           phase_q, phase_d;
	logic [LEN_W-1:0] len_q, len_d;
	logic [LEN_W-1:0] cnt_q, cnt_d;
	logic [BYTE_W-1:0] store_q [KEY_BYTES];

	logic                   emit, wr_en, advance, out_free, full_match, is_report;
	key_hit_t               key_hit;
	logic                   res_matched;
	logic [KEY_ID_W-1:0]    res_key_id;
	logic [BYTE_W-1:0]      res_key_value;
	logic [FRAME_LEN_W-1:0] res_frame_length;

	logic                   out_valid_q;
	logic                   matched_q;
	logic [KEY_ID_W-1:0]    key_id_q;
	logic [BYTE_W-1:0]      key_value_q;
	logic [FRAME_LEN_W-1:0] frame_length_q;

	assign out_free  = !out_valid_q || dout.ready;
	assign advance   = valid_s1 && (!emit || out_free);
	assign din.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (din.ready) begin
			valid_s1 <= din.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (din.valid && din.ready) begin
			byte_s1 <= din.rx_byte;
		end
	end

	assign key_hit    = dkf_key_lookup(store_q[1], store_q[2]);
	assign is_report  = (len_q == LEN_W'(REPORT_LEN));
	assign full_match = is_report && store_q[0] == TOUCH_CMD && store_q[3] == ADDR_BYTE3
		&& store_q[4] == ADDR_BYTE4 && key_hit.hit;

	always_comb begin
		phase_d          = phase_q;
		len_d            = len_q;
		cnt_d            = cnt_q;
		emit             = 1'b0;
		wr_en            = 1'b0;
		res_matched      = 1'b0;
		res_key_id       = '0;
		res_key_value    = '0;
		res_frame_length = '0;
		case (phase_q)
			PH_HUNT: begin
				if (byte_s1 == HDR_FIRST) phase_d = PH_HDR2;
			end
			PH_HDR2: begin
				phase_d = (byte_s1 == HDR_SECOND) ? PH_LEN : PH_HUNT;
			end
			PH_LEN: begin
				cnt_d = '0;
				if (byte_s1 > BYTE_W'(MAX_PAYLOAD)) begin
					phase_d = PH_HUNT;
					len_d   = '0;
				end else if (byte_s1 == '0) begin
					phase_d = PH_HUNT;
					len_d   = '0;
					emit    = 1'b1;
				end else begin
					phase_d = PH_DATA;
					len_d   = byte_s1[LEN_W-1:0];
				end
			end
			PH_DATA: begin
				wr_en = (cnt_q < LEN_W'(KEY_BYTES));
				cnt_d = cnt_q + 1'b1;
				if (cnt_d == len_q) begin
					emit             = 1'b1;
					phase_d          = PH_HUNT;
					len_d            = '0;
					cnt_d            = '0;
					res_matched      = full_match;
					res_key_id       = full_match ? key_hit.id : '0;
					res_key_value    = is_report ? byte_s1 : '0;
					res_frame_length = len_q[FRAME_LEN_W-1:0];
				end
			end
			default: begin
				phase_d = PH_HUNT;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT;
			len_q   <= '0;
			cnt_q   <= '0;
		end else if (advance) begin
			phase_q <= phase_d;
			len_q   <= len_d;
			cnt_q   <= cnt_d;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && wr_en) begin
			store_q[cnt_q[KEY_IDX_W-1:0]] <= byte_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= advance && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			matched_q      <= res_matched;
			key_id_q       <= res_key_id;
			key_value_q    <= res_key_value;
			frame_length_q <= res_frame_length;
		end
	end

	assign dout.valid        = out_valid_q;
	assign dout.matched      = matched_q;
	assign dout.key_id       = key_id_q;
	assign dout.key_value    = key_value_q;
	assign dout.frame_length = frame_length_q;

	`DKF_ASSERT(a_match_len, out_valid_q && matched_q |-> frame_length_q == FRAME_LEN_W'(REPORT_LEN), "match on a frame that is not a key report")
	`DKF_ASSERT(a_unmatched_id, out_valid_q && !matched_q |-> key_id_q == '0, "nonzero key id on unmatched frame")
	`DKF_ASSERT(a_cnt_below_len, phase_q == PH_DATA |-> cnt_q < len_q, "payload count reached length while collecting")
	`DKF_ASSERT(a_resync, advance && emit |=> phase_q == PH_HUNT, "no return to hunting after a completed frame")
	`DKF_ASSERT_ALWAYS(a_len_range, phase_q == PH_DATA |-> len_q != '0 && len_q <= LEN_W'(MAX_PAYLOAD), "frame length out of range")

endmodule
